>>> rtl/core/tcm_pkg.sv
// tcm_pkg: shared types, codes and the period rom of the channel modulator
// used by the register write interface and the top level; no dependencies

package tcm_pkg;

  localparam int ARP_STEPS    = 12;
  localparam int VIB_DEPTH_DEF = 256;
  localparam int ROM_LAST     = 83;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [15:0] PERIOD_MAX = 16'h1AC0;
  localparam logic [3:0]  ARP_LAST   = 4'd11;

  localparam logic [2:0] FUNC_TICK     = 3'd0;
  localparam logic [2:0] FUNC_NOTE     = 3'd1;
  localparam logic [2:0] FUNC_PORTA    = 3'd2;
  localparam logic [2:0] FUNC_LOAD_ARP = 3'd3;
  localparam logic [2:0] FUNC_LOAD_VIB = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ENV_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_LVL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_INC  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIB_WAIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VIB_AMP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VIB_SPEED  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VIB_LENGTH = 3'd6;

  typedef struct packed {
    logic [2:0]        func;
    logic [6:0]        note;
    logic [7:0]        transpose;
    logic [7:0]        glide_step;
    logic [7:0]        entry_index;
    logic signed [7:0] entry_value;
  } item_t;

  function automatic logic [15:0] period_rom(input logic [6:0] idx);
    logic [15:0] p;
    case (idx)
      7'd0:  p = 16'h1AC0;  7'd1:  p = 16'h1940;  7'd2:  p = 16'h17D0;
      7'd3:  p = 16'h1680;  7'd4:  p = 16'h1530;  7'd5:  p = 16'h1400;
      7'd6:  p = 16'h12E0;  7'd7:  p = 16'h11D0;  7'd8:  p = 16'h10D0;
      7'd9:  p = 16'h0FE0;  7'd10: p = 16'h0F00;  7'd11: p = 16'h0E20;
      7'd12: p = 16'h0D60;  7'd13: p = 16'h0CA0;  7'd14: p = 16'h0BE8;
      7'd15: p = 16'h0B40;  7'd16: p = 16'h0A98;  7'd17: p = 16'h0A00;
      7'd18: p = 16'h0970;  7'd19: p = 16'h08E8;  7'd20: p = 16'h0868;
      7'd21: p = 16'h07F0;  7'd22: p = 16'h0780;  7'd23: p = 16'h0710;
      7'd24: p = 16'h06B0;  7'd25: p = 16'h0650;  7'd26: p = 16'h05F4;
      7'd27: p = 16'h05A0;  7'd28: p = 16'h054C;  7'd29: p = 16'h0500;
      7'd30: p = 16'h04B8;  7'd31: p = 16'h0474;  7'd32: p = 16'h0434;
      7'd33: p = 16'h03F8;  7'd34: p = 16'h03C0;  7'd35: p = 16'h0388;
      7'd36: p = 16'h0358;  7'd37: p = 16'h0328;  7'd38: p = 16'h02FA;
      7'd39: p = 16'h02D0;  7'd40: p = 16'h02A6;  7'd41: p = 16'h0280;
      7'd42: p = 16'h025C;  7'd43: p = 16'h023A;  7'd44: p = 16'h021A;
      7'd45: p = 16'h01FC;  7'd46: p = 16'h01E0;  7'd47: p = 16'h01C4;
      7'd48: p = 16'h01AC;  7'd49: p = 16'h0194;  7'd50: p = 16'h017D;
      7'd51: p = 16'h0168;  7'd52: p = 16'h0153;  7'd53: p = 16'h0140;
      7'd54: p = 16'h012E;  7'd55: p = 16'h011D;  7'd56: p = 16'h010D;
      7'd57: p = 16'h00FE;  7'd58: p = 16'h00F0;  7'd59: p = 16'h00E2;
      7'd60: p = 16'h00D6;  7'd61: p = 16'h00CA;  7'd62: p = 16'h00BE;
      7'd63: p = 16'h00B4;  7'd64: p = 16'h00AA;  7'd65: p = 16'h00A0;
      7'd66: p = 16'h0097;  7'd67: p = 16'h008F;  7'd68: p = 16'h0087;
      7'd69: p = 16'h007F;  7'd70: p = 16'h0078;
      default: p = 16'h0071;
    endcase
    return p;
  endfunction

  // note sum clamped into the rom
  function automatic logic [15:0] period_lookup(input logic signed [10:0] idx);
    logic [6:0] i;
    if (idx < 11'sd0) begin
      i = 7'd0;
    end else if (idx > 11'(ROM_LAST)) begin
      i = 7'(ROM_LAST);
    end else begin
      i = idx[6:0];
    end
    return period_rom(i);
  endfunction

endpackage

>>> rtl/core/tcm_item_if.sv
// tcm_item_if: input item channel of the channel modulator
// no dependencies

interface tcm_item_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                func;
  logic [6:0]                note;
  logic [7:0]                transpose;
  logic [7:0]                glide_step;
  logic [7:0]                entry_index;
  logic signed [7:0]         entry_value;

  modport source (output valid, func, note, transpose, glide_step, entry_index,
                  entry_value, input ready);
  modport sink   (input valid, func, note, transpose, glide_step, entry_index,
                  entry_value, output ready);
endinterface

>>> rtl/core/tcm_result_if.sv
// tcm_result_if: result channel of the channel modulator
// no dependencies

interface tcm_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] period_out;
  logic [5:0]         volume_out;

  modport source (output valid, period_out, volume_out, input ready);
  modport sink   (input valid, period_out, volume_out, output ready);
endinterface

>>> rtl/core/tcm_cfg_if.sv
// tcm_cfg_if: register write channel of the channel modulator
// depends on tcm_pkg for the index and data widths

interface tcm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tcm_pkg::CFG_IDX_W-1:0]     index;
  logic [tcm_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/tracker_channel_modulator.sv
// tracker_channel_modulator: per-tick period and volume modulation of one channel
// depends on tcm_pkg, tcm_item_if, tcm_result_if and tcm_cfg_if
//
// channel   role    payload
// item_i    sink    func, note, transpose, glide_step, entry_index, entry_value
// result_o  source  period_out, volume_out (one per item)
// cfg_i     sink    index, data (always ready)
//
// one item per cycle sustained while the result is not stalled
// the input register feeds one pass of logic into the result register and state
// the vibrato wave memory is read into a register at the next position; it is not reset
// reset clears the channel state, the arpeggio table and the registers; no clearing pass
// a stalled result holds; input stays ready while the input register can drain

module tracker_channel_modulator #(
  parameter int VIB_DEPTH = tcm_pkg::VIB_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tcm_item_if.sink            item_i,
  tcm_result_if.source        result_o,
  tcm_cfg_if.sink             cfg_i
);
  import tcm_pkg::*;

  localparam int VIB_AW = (VIB_DEPTH > 1) ? $clog2(VIB_DEPTH) : 1;
  localparam int IW     = (VIB_AW > 8) ? VIB_AW : 8;
  localparam logic [IW:0] VIB_LIM = (IW+1)'(VIB_DEPTH);

  // handshake and pipeline
  logic  in_valid_q, out_valid_q, adv;
  item_t in_q;
  logic signed [15:0] period_q, period_d;

  // registers
  logic [7:0]  env_speed_q, vib_wait_q, vib_amp_q, vib_speed_q;
  logic [23:0] stage_lvl_q;
  logic [31:0] stage_inc_q;
  logic [8:0]  vib_len_q;

  // channel state
  logic [6:0]  cur_note_q, cur_note_d;
  logic [7:0]  cur_tra_q, cur_tra_d;
  logic [15:0] base_q, base_d, goal_q, goal_d;
  logic [7:0]  glide_q, glide_d;
  logic [5:0]  vol_q, vol_d;
  logic [1:0]  stage_q, stage_d;
  logic [7:0]  env_cnt_q, env_cnt_d;
  logic [9:0]  vib_delay_q, vib_delay_d;
  logic [7:0]  vib_pos_q, vib_pos_d, vib_pos_nx;
  logic [3:0]  arp_pos_q, arp_pos_d;
  logic signed [7:0] arp_tab_q [ARP_STEPS];
  logic              arp_we;

  // vibrato wave memory
  logic [7:0]        vib_mem [VIB_DEPTH];
  logic signed [7:0] vib_rd_q;
  logic              vib_we;
  logic [IW-1:0]     widx, ridx;
  logic [VIB_AW-1:0] waddr, raddr;

  assign adv          = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || adv;
  assign cfg_i.ready  = 1'b1;

  assign result_o.valid      = out_valid_q;
  assign result_o.period_out = period_q;
  assign result_o.volume_out = vol_q;

  assign widx   = IW'(in_q.entry_index);
  assign waddr  = widx[VIB_AW-1:0];
  assign vib_we = adv && (in_q.func == FUNC_LOAD_VIB) && ({1'b0, widx} < VIB_LIM);
  assign arp_we = adv && (in_q.func == FUNC_LOAD_ARP) &&
                  (in_q.entry_index < 8'(ARP_STEPS));

  assign vib_pos_nx = adv ? vib_pos_d : vib_pos_q;
  assign ridx       = IW'(vib_pos_nx);
  assign raddr      = ridx[VIB_AW-1:0];

  always_comb begin
    logic signed [7:0]  off;
    logic signed [10:0] nsum;
    logic signed [17:0] b18, g18, s18, gp;
    logic signed [16:0] prod;
    logic signed [15:0] vib_v;
    logic signed [9:0]  np, ev, aim, inc;
    logic [IW-1:0]      pidx;
    logic [15:0]        rom_p;

    cur_note_d  = cur_note_q;
    cur_tra_d   = cur_tra_q;
    base_d      = base_q;
    goal_d      = goal_q;
    glide_d     = glide_q;
    vol_d       = vol_q;
    stage_d     = stage_q;
    env_cnt_d   = env_cnt_q;
    vib_delay_d = vib_delay_q;
    vib_pos_d   = vib_pos_q;
    arp_pos_d   = arp_pos_q;
    vib_v       = 16'sd0;
    off         = (arp_pos_q < 4'(ARP_STEPS)) ? arp_tab_q[arp_pos_q] : 8'sd0;
    b18         = 18'(base_q);
    g18         = 18'(goal_q);
    s18         = 18'(glide_q);
    gp          = b18;
    pidx        = IW'(vib_pos_q);
    prod        = vib_rd_q * $signed({1'b0, vib_amp_q});
    np          = $signed(10'(vib_pos_q)) - $signed(10'(vib_speed_q));
    ev          = 10'(vol_q);
    aim         = 10'(stage_lvl_q[6*stage_q +: 6]);
    inc         = 10'(stage_inc_q[8*stage_q +: 8]);
    nsum        = 11'(in_q.note) + 11'(cur_tra_q);
    rom_p       = 16'd0;

    case (in_q.func)
      FUNC_TICK: begin
        if (glide_q != 8'd0) begin
          if (b18 < g18) begin
            gp = b18 + s18;
            if (gp >= g18) gp = g18;
          end else begin
            gp = b18 - s18;
            if (gp <= g18) gp = g18;
          end
          base_d = gp[15:0];
        end else begin
          nsum   = 11'(cur_note_q) + 11'(cur_tra_q) + 11'(off);
          base_d = period_lookup(nsum);
          arp_pos_d = (arp_pos_q == 4'd0 || arp_pos_q >= 4'(ARP_STEPS)) ?
                      ARP_LAST : arp_pos_q - 4'd1;
        end
        if (vib_speed_q != 8'd0) begin
          if (vib_delay_q != 10'd0) begin
            vib_delay_d = vib_delay_q - 10'd1;
          end else begin
            if ({1'b0, pidx} < VIB_LIM) vib_v = prod[15:0];
            if (np < 10'sd0) np = np + $signed(10'(vib_len_q));
            vib_pos_d = np[7:0];
          end
        end
        if (env_cnt_q != 8'd0) begin
          env_cnt_d = env_cnt_q - 8'd1;
        end else begin
          env_cnt_d = env_speed_q;
          if (ev >= aim) begin
            ev = ev - inc;
            if (ev <= aim) begin
              ev = aim;
              if (stage_q != 2'd3) stage_d = stage_q + 2'd1;
            end
          end else begin
            ev = ev + inc;
            if (ev >= aim) begin
              ev = aim;
              if (stage_q != 2'd3) stage_d = stage_q + 2'd1;
            end
          end
          vol_d = ev[5:0];
        end
      end
      FUNC_NOTE: begin
        cur_note_d = in_q.note;
        cur_tra_d  = in_q.transpose;
        nsum       = 11'(in_q.note) + 11'(in_q.transpose);
        base_d     = period_lookup(nsum);
        vol_d      = 6'd0;
        glide_d    = 8'd0;
        stage_d    = 2'd0;
        vib_pos_d  = 8'd0;
        if (vib_wait_q != 8'd0) vib_delay_d = {vib_wait_q, 2'b00} - 10'd1;
      end
      FUNC_PORTA: begin
        rom_p     = period_lookup(nsum);
        goal_d    = rom_p;
        glide_d   = in_q.glide_step;
        stage_d   = 2'd0;
        vib_pos_d = 8'd0;
        if (vib_wait_q != 8'd0) vib_delay_d = {vib_wait_q, 2'b00} - 10'd1;
      end
      default: begin
      end
    endcase

    period_d = $signed(base_d) + vib_v;
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_i.ready) in_valid_q <= item_i.valid;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_q.func        <= item_i.func;
      in_q.note        <= item_i.note;
      in_q.transpose   <= item_i.transpose;
      in_q.glide_step  <= item_i.glide_step;
      in_q.entry_index <= item_i.entry_index;
      in_q.entry_value <= item_i.entry_value;
    end
    if (adv) period_q <= period_d;
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_speed_q <= '0;
      stage_lvl_q <= '0;
      stage_inc_q <= '0;
      vib_wait_q  <= '0;
      vib_amp_q   <= '0;
      vib_speed_q <= '0;
      vib_len_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ENV_SPEED:  env_speed_q <= cfg_i.data[7:0];
        REG_STAGE_LVL:  stage_lvl_q <= cfg_i.data[23:0];
        REG_STAGE_INC:  stage_inc_q <= cfg_i.data[31:0];
        REG_VIB_WAIT:   vib_wait_q  <= cfg_i.data[7:0];
        REG_VIB_AMP:    vib_amp_q   <= cfg_i.data[7:0];
        REG_VIB_SPEED:  vib_speed_q <= cfg_i.data[7:0];
        REG_VIB_LENGTH: vib_len_q   <= cfg_i.data[8:0];
        default: begin
        end
      endcase
    end
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_note_q  <= '0;
      cur_tra_q   <= '0;
      base_q      <= '0;
      goal_q      <= '0;
      glide_q     <= '0;
      vol_q       <= '0;
      stage_q     <= '0;
      env_cnt_q   <= '0;
      vib_delay_q <= '0;
      vib_pos_q   <= '0;
      arp_pos_q   <= '0;
      for (int i = 0; i < ARP_STEPS; i++) arp_tab_q[i] <= '0;
    end else if (adv) begin
      cur_note_q  <= cur_note_d;
      cur_tra_q   <= cur_tra_d;
      base_q      <= base_d;
      goal_q      <= goal_d;
      glide_q     <= glide_d;
      vol_q       <= vol_d;
      stage_q     <= stage_d;
      env_cnt_q   <= env_cnt_d;
      vib_delay_q <= vib_delay_d;
      vib_pos_q   <= vib_pos_d;
      arp_pos_q   <= arp_pos_d;
      if (arp_we) arp_tab_q[in_q.entry_index[3:0]] <= in_q.entry_value;
    end
  end

  // wave memory, write-first read at the next position
  always_ff @(posedge clk_i) begin
    if (vib_we) vib_mem[waddr] <= in_q.entry_value;
    if (vib_we && (waddr == raddr)) begin
      vib_rd_q <= in_q.entry_value;
    end else begin
      vib_rd_q <= $signed(vib_mem[raddr]);
    end
  end

`ifndef ASSERT_OFF
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_i.ready |-> (in_valid_q && out_valid_q && !result_o.ready))
    else $error("input stalled without a full pipeline");

  a_note_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.func == FUNC_NOTE) |=> (glide_q == 8'd0 && stage_q == 2'd0 &&
    vol_q == 6'd0 && vib_pos_q == 8'd0))
    else $error("note start did not clear glide, envelope and vibrato");

  a_arp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arp_pos_q < 4'(ARP_STEPS))
    else $error("arpeggio position out of range");

  a_base_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q <= PERIOD_MAX && goal_q <= PERIOD_MAX)
    else $error("period state out of rom range");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result raised without an item in the input register");
`endif

endmodule
